// ===== design/hfs_pkg.sv =====
// Package of shared types, constants and functions for the HSV fade sequencer.
`default_nettype none

package hfs_pkg;

  localparam int RAMP_LENGTH_DEF = 30;
  localparam int TABLE_SIZE      = 30;
  localparam int IDX_W           = 5;
  localparam int HUE_W           = 9;
  localparam int CH_W            = 8;
  localparam int DEG_PER_REGION  = 60;
  localparam logic [CH_W-1:0] FULL_SCALE  = 8'd255;
  localparam logic [CH_W-1:0] VALUE_RESET = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
    logic empty;
  } dp_status_t;

  function automatic logic [CH_W-1:0] ramp_lookup(input logic [IDX_W-1:0] idx);
    logic [CH_W-1:0] s;
    unique case (idx)
      5'd0:    s = 8'd1;
      5'd1:    s = 8'd2;
      5'd2:    s = 8'd3;
      5'd3:    s = 8'd4;
      5'd4:    s = 8'd5;
      5'd5:    s = 8'd7;
      5'd6:    s = 8'd9;
      5'd7:    s = 8'd11;
      5'd8:    s = 8'd14;
      5'd9:    s = 8'd18;
      5'd10:   s = 8'd23;
      5'd11:   s = 8'd29;
      5'd12:   s = 8'd37;
      5'd13:   s = 8'd47;
      5'd14:   s = 8'd59;
      5'd15:   s = 8'd74;
      5'd16:   s = 8'd93;
      5'd17:   s = 8'd116;
      5'd18:   s = 8'd145;
      5'd19:   s = 8'd160;
      5'd20:   s = 8'd176;
      5'd21:   s = 8'd189;
      5'd22:   s = 8'd203;
      5'd23:   s = 8'd215;
      5'd24:   s = 8'd226;
      5'd25:   s = 8'd235;
      5'd26:   s = 8'd242;
      5'd27:   s = 8'd247;
      5'd28:   s = 8'd251;
      5'd29:   s = 8'd255;
      default: s = 8'd255;
    endcase
    return s;
  endfunction

  // Exact floor(x / 255) for every product of two 8-bit values.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] sum;
    sum = {1'b0, x} + 17'(x[2*CH_W-1:CH_W]) + 17'd1;
    return sum[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

// ===== design/hfs_in_if.sv =====
// Input channel interface carrying one hue per beat.
`default_nettype none

interface hfs_in_if;
  logic                      valid;
  logic                      ready;
  logic [hfs_pkg::HUE_W-1:0] hue;

  modport source (output valid, output hue, input ready);
  modport sink   (input valid, input hue, output ready);
endinterface

`default_nettype wire

// ===== design/hfs_out_if.sv =====
// Result channel interface carrying one RGB color per beat.
`default_nettype none

interface hfs_out_if;
  logic                     valid;
  logic                     ready;
  logic [hfs_pkg::CH_W-1:0] red;
  logic [hfs_pkg::CH_W-1:0] green;
  logic [hfs_pkg::CH_W-1:0] blue;
  logic                     last_step;

  modport source (output valid, output red, output green, output blue,
                  output last_step, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_step, output ready);
endinterface

`default_nettype wire

// ===== design/hsv_fade_sequencer_top.sv =====
// Top level of the HSV fade sequencer: controller, datapath and channel wiring.
// Each accepted hue yields 2*L color beats, L = RAMP_LENGTH clamped to 1..30, one per cycle when not stalled.
// After a hue is accepted, each beat passes through four pipeline stages before it is valid.
// A new hue is taken only after the last beat has left and the controller has returned to idle.
// The ramp counter in the controller paces the beats; backpressure stalls the pipeline.
// Synchronous active-low reset clears all control state and sets value_r to 255.
`default_nettype none

module hsv_fade_sequencer_top #(
  parameter int RAMP_LENGTH = hfs_pkg::RAMP_LENGTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  hfs_in_if.sink                        in_ch,
  hfs_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [hfs_pkg::CH_W-1:0] cfg_wdata
);

  hfs_pkg::dp_cmd_t    cmd;
  hfs_pkg::dp_status_t status;

  hfs_ctrl #(
    .RAMP_LENGTH(RAMP_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hfs_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .hue           (in_ch.hue),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_red       (out_ch.red),
    .out_green     (out_ch.green),
    .out_blue      (out_ch.blue),
    .out_last_step (out_ch.last_step)
  );

endmodule

`default_nettype wire

// ===== design/hfs_ctrl.sv =====
// Controller that sequences the ramp walk of one fade per accepted hue.
`default_nettype none

module hfs_ctrl #(
  parameter int RAMP_LENGTH = hfs_pkg::RAMP_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hfs_pkg::dp_status_t status,
  output hfs_pkg::dp_cmd_t         cmd
);

  localparam int LEN    = (RAMP_LENGTH > hfs_pkg::TABLE_SIZE) ? hfs_pkg::TABLE_SIZE :
                          ((RAMP_LENGTH < 1) ? 1 : RAMP_LENGTH);
  localparam int STEP_W = (2 * LEN > 2) ? $clog2(2 * LEN) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * LEN - 1);
  localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(LEN);

  hfs_pkg::state_t   state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfs_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.issue = 1'b0;
    cmd.last  = (step_r == STEP_LAST);
    if (step_r < STEP_TOP) begin
      cmd.idx = hfs_pkg::IDX_W'(step_r);
    end else begin
      cmd.idx = hfs_pkg::IDX_W'(STEP_LAST - step_r);
    end
    unique case (state_r)
      hfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = hfs_pkg::ST_RUN;
        end
      end
      hfs_pkg::ST_RUN: begin
        cmd.issue = status.adv;
        if (status.adv) begin
          if (step_r == STEP_LAST) begin
            state_nxt = hfs_pkg::ST_DRAIN;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      hfs_pkg::ST_DRAIN: begin
        if (status.empty) begin
          state_nxt = hfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hfs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hfs_datapath.sv =====
// Four-stage HSV-to-RGB pipeline with the value register and the output register.
`default_nettype none

module hfs_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [hfs_pkg::HUE_W-1:0]   hue,
  input  wire logic                        cfg_we,
  input  wire logic [hfs_pkg::CH_W-1:0]    cfg_wdata,
  input  wire hfs_pkg::dp_cmd_t            cmd,
  output hfs_pkg::dp_status_t              status,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [hfs_pkg::CH_W-1:0]         out_red,
  output logic [hfs_pkg::CH_W-1:0]         out_green,
  output logic [hfs_pkg::CH_W-1:0]         out_blue,
  output logic                             out_last_step
);

  localparam int W  = hfs_pkg::CH_W;
  localparam int PW = 2 * hfs_pkg::CH_W;

  logic [W-1:0] value_r;

  logic [3:0]         region_full;
  logic [5:0]         hue_mod;
  logic [W-1:0]       rem_calc;
  hfs_pkg::sector_t   sec_calc;
  hfs_pkg::sector_t   sec_r;
  logic [W-1:0]       rem_r;

  logic               adv;
  logic [W-1:0]       s_cur;

  logic               v1_r, v2_r, v3_r;
  logic               l1_r, l2_r, l3_r;
  hfs_pkg::sector_t   c1_r, c2_r, c3_r;
  logic [PW-1:0]      m1_r, m2_r, mp_r;
  logic [W-1:0]       qa_r, ta_r, p2_r, p3_r;
  logic [PW-1:0]      mq_r, mt_r;
  logic [W-1:0]       q4, t4;
  logic [W-1:0]       r_nxt, g_nxt, b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= hfs_pkg::VALUE_RESET;
    end else if (cfg_we) begin
      value_r <= cfg_wdata;
    end
  end

  always_comb begin
    region_full = '0;
    for (int k = 1; k <= 8; k++) begin
      if (hue >= hfs_pkg::HUE_W'(k * hfs_pkg::DEG_PER_REGION)) begin
        region_full = 4'(k);
      end
    end
    hue_mod  = 6'(hue - hfs_pkg::HUE_W'(int'(region_full) * hfs_pkg::DEG_PER_REGION));
    rem_calc = 8'((10'(hue_mod) * 10'd17) >> 2);
    if (region_full >= 4'd5) begin
      sec_calc = hfs_pkg::SEC_MR;
    end else begin
      sec_calc = hfs_pkg::sector_t'(region_full[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r <= sec_calc;
      rem_r <= rem_calc;
    end
  end

  assign adv          = !out_valid || out_ready;
  assign status.adv   = adv;
  assign status.empty = !(v1_r || v2_r || v3_r || out_valid);
  assign s_cur        = hfs_pkg::ramp_lookup(cmd.idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= cmd.issue;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r <= cmd.last;
      c1_r <= sec_r;
      m1_r <= PW'(s_cur) * PW'(rem_r);
      m2_r <= PW'(s_cur) * PW'(hfs_pkg::FULL_SCALE - rem_r);
      mp_r <= PW'(value_r) * PW'(hfs_pkg::FULL_SCALE - s_cur);

      l2_r <= l1_r;
      c2_r <= c1_r;
      qa_r <= hfs_pkg::FULL_SCALE - hfs_pkg::div255(m1_r);
      ta_r <= hfs_pkg::FULL_SCALE - hfs_pkg::div255(m2_r);
      p2_r <= hfs_pkg::div255(mp_r);

      l3_r <= l2_r;
      c3_r <= c2_r;
      mq_r <= PW'(value_r) * PW'(qa_r);
      mt_r <= PW'(value_r) * PW'(ta_r);
      p3_r <= p2_r;

      out_last_step <= l3_r;
      out_red       <= r_nxt;
      out_green     <= g_nxt;
      out_blue      <= b_nxt;
    end
  end

  assign q4 = hfs_pkg::div255(mq_r);
  assign t4 = hfs_pkg::div255(mt_r);

  always_comb begin
    unique case (c3_r)
      hfs_pkg::SEC_RY: begin r_nxt = value_r; g_nxt = t4;      b_nxt = p3_r;    end
      hfs_pkg::SEC_YG: begin r_nxt = q4;      g_nxt = value_r; b_nxt = p3_r;    end
      hfs_pkg::SEC_GC: begin r_nxt = p3_r;    g_nxt = value_r; b_nxt = t4;      end
      hfs_pkg::SEC_CB: begin r_nxt = p3_r;    g_nxt = q4;      b_nxt = value_r; end
      hfs_pkg::SEC_BM: begin r_nxt = t4;      g_nxt = p3_r;    b_nxt = value_r; end
      default:         begin r_nxt = value_r; g_nxt = p3_r;    b_nxt = q4;      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hfs_checker.sv =====
// Port-level checker for the HSV fade sequencer and its bind to the top level.
`default_nettype none

module hfs_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [hfs_pkg::CH_W-1:0] out_red,
  input wire logic [hfs_pkg::CH_W-1:0] out_green,
  input wire logic [hfs_pkg::CH_W-1:0] out_blue,
  input wire logic                     out_last_step
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_last_step))
    else $error("stalled result beat changed");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results are pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted hue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_step |=> !out_valid)
    else $error("result beat follows the last step");

endmodule

bind hsv_fade_sequencer_top hfs_checker u_hfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_red       (out_ch.red),
  .out_green     (out_ch.green),
  .out_blue      (out_ch.blue),
  .out_last_step (out_ch.last_step)
);

`default_nettype wire
